>>> sv/ltlp_pkg.sv
// Shared constants, codes and types of the latency table line parser.
// Used by latency_table_line_parser; depends on nothing else.
`default_nettype none

package ltlp_pkg;

   localparam int unsigned MaxNodes      = 64;
   localparam int unsigned NodeBits      = $clog2(MaxNodes);
   localparam int unsigned TableAddrBits = 2 * NodeBits;
   localparam int unsigned LineChars     = 80;
   localparam int unsigned ColBits       = $clog2(LineChars + 1);
   localparam int unsigned CountBits     = NodeBits + 1;
   localparam int unsigned TimeBits      = 31;

   localparam longint unsigned TimeMaxInt = (64'd1 << TimeBits) - 64'd1;
   localparam logic [TimeBits-1:0] TimeMax  = TimeBits'(TimeMaxInt);
   localparam logic [TimeBits-1:0] SatLimit = TimeBits'(TimeMaxInt / 10);
   localparam logic [3:0]          SatRem   = 4'(TimeMaxInt % 10);

   localparam logic [CountBits-1:0] NodeCountReset = CountBits'(MaxNodes);
   localparam logic [CountBits-1:0] NodesMax       = CountBits'(MaxNodes);

   // Characters the parser recognizes.
   localparam logic [7:0] ChNewline = 8'h0A;
   localparam logic [7:0] ChSpace   = 8'h20;
   localparam logic [7:0] ChHash    = 8'h23;
   localparam logic [7:0] ChDash    = 8'h2D;
   localparam logic [7:0] ChGt      = 8'h3E;
   localparam logic [7:0] ChColon   = 8'h3A;
   localparam logic [7:0] ChZero    = 8'h30;
   localparam logic [7:0] ChNine    = 8'h39;

   // Request kinds.
   localparam logic [1:0] ReqText   = 2'd0;
   localparam logic [1:0] ReqLookup = 2'd1;
   localparam logic [1:0] ReqEnd    = 2'd2;

   // Parse phases.
   localparam logic [3:0] PhLead    = 4'd0;
   localparam logic [3:0] PhSrc     = 4'd1;
   localparam logic [3:0] PhArrow   = 4'd2;
   localparam logic [3:0] PhArrow2  = 4'd3;
   localparam logic [3:0] PhPreDest = 4'd4;
   localparam logic [3:0] PhDest    = 4'd5;
   localparam logic [3:0] PhColon   = 4'd6;
   localparam logic [3:0] PhPreTime = 4'd7;
   localparam logic [3:0] PhTime    = 4'd8;
   localparam logic [3:0] PhDone    = 4'd9;

   // Result status codes.
   localparam logic [3:0] StatusStored      = 4'd0;
   localparam logic [3:0] StatusBlank       = 4'd1;
   localparam logic [3:0] StatusNotNumber   = 4'd2;
   localparam logic [3:0] StatusTooHigh     = 4'd3;
   localparam logic [3:0] StatusNoArrow     = 4'd4;
   localparam logic [3:0] StatusNoColon     = 4'd5;
   localparam logic [3:0] StatusBadTime     = 4'd6;
   localparam logic [3:0] StatusLookupOk    = 4'd7;
   localparam logic [3:0] StatusLookupRange = 4'd8;

   // Register byte addresses.
   localparam logic [2:0] CsrNodeCount = 3'd0;

   typedef struct packed {
      logic [3:0]          phase;
      logic [TimeBits-1:0] acc;
      logic [NodeBits-1:0] src;
      logic [NodeBits-1:0] dest;
      logic [2:0]          verdict;
   } parse_type;

   typedef struct packed {
      parse_type ps;
      logic      again;
   } step_type;

endpackage

`default_nettype wire

>>> sv/latency_table_line_parser.sv
// Latency table line parser: character parser, latency table memory and result pipeline.
// Depends on ltlp_pkg.
//
// The block reads text one character per transfer and parses lines of the form
// "src -> dest : time"; each finished line gives one status transfer, and a valid line
// writes its time into a 64 x 64 latency table held in a single-port-write,
// single-port-read synchronous memory. A lookup request reads that table. One request is
// taken every clock cycle unless the clearing pass runs or the output stalls; text
// characters that do not end a line give no result. A result passes through the parse
// or table-read stage register and then the output register. The rate is set by the
// table memory, which serves one write (line end) or one read (lookup) per cycle. After
// reset a clearing pass writes 1 into every table entry, one entry a cycle, and
// req_tready stays low until it ends; register writes are taken throughout.
`default_nettype none

module latency_table_line_parser
   import ltlp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // [7:0] ch, [13:8] src_node, [19:14] dest_node, [23:20] zero
   input  wire logic [23:0] req_tdata,
   // [1:0] req_type
   input  wire logic [1:0]  req_tuser,

   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // [30:0] travel_time, [31] zero
   output      logic [31:0] rsp_tdata,
   // [3:0] status
   output      logic [3:0]  rsp_tuser,

   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output      logic [31:0] csr_prdata,
   output      logic        csr_pready
);

   // Configuration.
   logic [CountBits-1:0] node_count_ff;
   logic [CountBits-1:0] nodes_used;
   logic                 csr_write;

   // Parser state.
   parse_type            parse_ff, parse_in;
   logic [ColBits-1:0]   column_ff, column_in;
   logic [ColBits-1:0]   col_inc;

   // Table clearing pass.
   logic                     clr_busy_ff;
   logic [TableAddrBits-1:0] clr_addr_ff;

   // Table memory.
   logic [TimeBits-1:0]      latency_mem_ff [2**TableAddrBits];
   logic [TimeBits-1:0]      rd_data_ff;
   logic                     mem_we;
   logic [TableAddrBits-1:0] mem_waddr;
   logic [TimeBits-1:0]      mem_wdata;
   logic                     tbl_we;
   logic                     tbl_re;

   // Request fields.
   logic [1:0]          req_type;
   logic [7:0]          ch;
   logic [NodeBits-1:0] src_node;
   logic [NodeBits-1:0] dest_node;
   logic                req_accept;

   // Parse steps.
   step_type  st_a, st_b, st_c, st_d;
   parse_type ps_char, end_pre, ps_end;
   logic      do_end;

   // Result of the accepted request.
   logic                res_valid;
   logic                res_lookup;
   logic [3:0]          res_status;
   logic [TimeBits-1:0] res_time;

   // Stage registers.
   logic                s1_valid_ff;
   logic                s1_lookup_ff;
   logic [3:0]          s1_status_ff;
   logic [TimeBits-1:0] s1_time_ff;
   logic                s1_advance;
   logic                out_valid_ff;
   logic [3:0]          out_status_ff;
   logic [TimeBits-1:0] out_time_ff;

   // One parser step on a character or on the end mark (which matches no token).
   function automatic step_type parse_step(parse_type ps, logic is_end, logic [7:0] c,
                                           logic [CountBits-1:0] n);
      step_type            r;
      logic                dig;
      logic                sp;
      logic [3:0]          d;
      logic [TimeBits-1:0] limit;
      logic [TimeBits-1:0] acc10;
      r       = '{ps: ps, again: 1'b0};
      dig     = !is_end && (c >= ChZero) && (c <= ChNine);
      sp      = !is_end && (c == ChSpace);
      d       = dig ? 4'(c - ChZero) : 4'd0;
      limit   = (d > SatRem) ? SatLimit - TimeBits'(1) : SatLimit;
      acc10   = (ps.acc << 3) + (ps.acc << 1) + TimeBits'(d);
      case (ps.phase)
         PhLead: begin
            if (sp) begin
               r.ps.phase = PhLead;
            end else if (!is_end && (c == ChHash || c == ChNewline)) begin
               r.ps.verdict = 3'(StatusBlank);
               r.ps.phase   = PhDone;
            end else if (dig) begin
               r.ps.acc   = TimeBits'(d);
               r.ps.phase = PhSrc;
            end else begin
               r.ps.verdict = 3'(StatusNotNumber);
               r.ps.phase   = PhDone;
            end
         end
         PhSrc, PhDest: begin
            if (dig) begin
               r.ps.acc = (ps.acc > limit) ? TimeMax : acc10;
            end else if (ps.acc >= TimeBits'(n)) begin
               r.ps.verdict = 3'(StatusTooHigh);
               r.ps.phase   = PhDone;
            end else begin
               // The terminating character is parsed again in the next phase.
               if (ps.phase == PhSrc) begin
                  r.ps.src   = NodeBits'(ps.acc);
                  r.ps.phase = PhArrow;
               end else begin
                  r.ps.dest  = NodeBits'(ps.acc);
                  r.ps.phase = PhColon;
               end
               r.again = 1'b1;
            end
         end
         PhArrow: begin
            if (sp) begin
               r.ps.phase = PhArrow;
            end else if (!is_end && c == ChDash) begin
               r.ps.phase = PhArrow2;
            end else begin
               r.ps.verdict = 3'(StatusNoArrow);
               r.ps.phase   = PhDone;
            end
         end
         PhArrow2: begin
            if (!is_end && c == ChGt) begin
               r.ps.phase = PhPreDest;
            end else begin
               r.ps.verdict = 3'(StatusNoArrow);
               r.ps.phase   = PhDone;
            end
         end
         PhPreDest, PhPreTime: begin
            if (sp) begin
               r.ps.phase = ps.phase;
            end else if (dig) begin
               r.ps.acc   = TimeBits'(d);
               r.ps.phase = (ps.phase == PhPreDest) ? PhDest : PhTime;
            end else begin
               r.ps.verdict = (ps.phase == PhPreDest) ? 3'(StatusNotNumber)
                                                      : 3'(StatusBadTime);
               r.ps.phase   = PhDone;
            end
         end
         PhColon: begin
            if (sp) begin
               r.ps.phase = PhColon;
            end else if (!is_end && c == ChColon) begin
               r.ps.phase = PhPreTime;
            end else begin
               r.ps.verdict = 3'(StatusNoColon);
               r.ps.phase   = PhDone;
            end
         end
         PhTime: begin
            if (dig) begin
               r.ps.acc = (ps.acc > limit) ? TimeMax : acc10;
            end else begin
               r.ps.verdict = (ps.acc == '0) ? 3'(StatusBadTime) : 3'(StatusStored);
               r.ps.phase   = PhDone;
            end
         end
         default: begin
            r.ps.phase = PhDone;
         end
      endcase
      return r;
   endfunction

   assign req_type  = req_tuser;
   assign ch        = req_tdata[7:0];
   assign src_node  = req_tdata[13:8];
   assign dest_node = req_tdata[19:14];

   assign nodes_used = (node_count_ff > NodesMax) ? NodesMax : node_count_ff;

   assign s1_advance = !out_valid_ff || rsp_tready;
   assign req_tready = !clr_busy_ff && (!s1_valid_ff || s1_advance);
   assign req_accept = req_tvalid && req_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_time_ff};
   assign rsp_tuser  = out_status_ff;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == CsrNodeCount[2]);
   assign csr_prdata = (csr_paddr[2] == CsrNodeCount[2]) ? 32'(node_count_ff) : 32'd0;

   // Character step, with a second pass when a number ends on a token character.
   assign st_a    = parse_step(parse_ff, 1'b0, ch, nodes_used);
   assign st_b    = parse_step(st_a.ps, 1'b0, ch, nodes_used);
   assign ps_char = st_a.again ? st_b.ps : st_a.ps;

   // Line end: feed the end mark unless the line is already decided.
   assign end_pre = (req_type == ReqText) ? ps_char : parse_ff;
   assign st_c    = parse_step(end_pre, 1'b1, 8'd0, nodes_used);
   assign st_d    = parse_step(st_c.ps, 1'b1, 8'd0, nodes_used);
   assign ps_end  = (end_pre.phase == PhDone) ? end_pre : (st_c.again ? st_d.ps : st_c.ps);

   assign col_inc = column_ff + ColBits'(1);

   always_comb begin
      parse_in   = parse_ff;
      column_in  = column_ff;
      do_end     = 1'b0;
      res_valid  = 1'b0;
      res_lookup = 1'b0;
      res_status = StatusStored;
      res_time   = '0;
      tbl_we     = 1'b0;
      tbl_re     = 1'b0;
      if (req_accept) begin
         case (req_type)
            ReqText: begin
               parse_in  = ps_char;
               column_in = col_inc;
               do_end    = (ch == ChNewline) || (col_inc >= ColBits'(LineChars));
            end
            ReqLookup: begin
               res_valid = 1'b1;
               if ({1'b0, src_node} >= nodes_used || {1'b0, dest_node} >= nodes_used) begin
                  res_status = StatusLookupRange;
               end else begin
                  res_status = StatusLookupOk;
                  res_lookup = 1'b1;
                  tbl_re     = 1'b1;
               end
            end
            ReqEnd: begin
               do_end = (column_ff != '0);
            end
            default: begin
               do_end = 1'b0;
            end
         endcase
         if (do_end) begin
            res_valid  = 1'b1;
            res_status = {1'b0, ps_end.verdict};
            if (ps_end.verdict == 3'(StatusStored)) begin
               res_time = ps_end.acc;
               tbl_we   = 1'b1;
            end
            parse_in         = ps_end;
            parse_in.phase   = PhLead;
            parse_in.verdict = '0;
            column_in        = '0;
         end
      end
   end

   assign mem_we    = clr_busy_ff || tbl_we;
   assign mem_waddr = clr_busy_ff ? clr_addr_ff : {ps_end.src, ps_end.dest};
   assign mem_wdata = clr_busy_ff ? TimeBits'(1) : ps_end.acc;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         latency_mem_ff[mem_waddr] <= mem_wdata;
      end
      if (tbl_re) begin
         rd_data_ff <= latency_mem_ff[{src_node, dest_node}];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NodeCountReset;
         parse_ff      <= '0;
         column_ff     <= '0;
         clr_busy_ff   <= 1'b1;
         clr_addr_ff   <= '0;
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_write) begin
            node_count_ff <= csr_pwdata[CountBits-1:0];
         end
         parse_ff  <= parse_in;
         column_ff <= column_in;
         if (clr_busy_ff) begin
            clr_addr_ff <= clr_addr_ff + TableAddrBits'(1);
            if (clr_addr_ff == '1) begin
               clr_busy_ff <= 1'b0;
            end
         end
         if (req_accept) begin
            s1_valid_ff <= res_valid;
         end else if (s1_advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_valid_ff && s1_advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_lookup_ff <= res_lookup;
         s1_status_ff <= res_status;
         s1_time_ff   <= res_time;
      end
      if (s1_valid_ff && s1_advance) begin
         out_status_ff <= s1_status_ff;
         out_time_ff   <= s1_lookup_ff ? rd_data_ff : s1_time_ff;
      end
   end

`ifndef ASSERT_OFF
   // A lookup inside the node range must reach the read stage as a table read.
   a_lookup_to_stage: assert property (@(posedge clock) disable iff (reset)
      (req_accept && tbl_re) |=> (s1_valid_ff && s1_lookup_ff))
      else $error("lookup read did not reach the read stage");

   // The column count never reaches the line length; the line ends there.
   a_column_bound: assert property (@(posedge clock) disable iff (reset)
      column_ff < ColBits'(LineChars))
      else $error("column count ran past the line length");

   // Only stored lines and successful lookups carry a time.
   a_time_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != StatusStored && rsp_tuser != StatusLookupOk)
         |-> (rsp_tdata == 32'd0))
      else $error("time reported with a status that has none");
`endif

endmodule

`default_nettype wire
